// File: src/disparity_to_point_reprojection_unit_macros.svh
// Assertion helpers shared by the RTL files
`ifndef DISPARITY_TO_POINT_REPROJECTION_UNIT_MACROS_SVH
`define DISPARITY_TO_POINT_REPROJECTION_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define D2P_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define D2P_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/d2p_pkg.sv
`default_nettype none
package d2p_pkg;

    typedef struct packed {
        logic [15:0] disparity_half;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [11:0]        pixel_column;
        logic [11:0]        pixel_row;
    } t_out_item;

    localparam logic [2:0] REG_FOCAL   = 3'd0;
    localparam logic [2:0] REG_CX      = 3'd1;
    localparam logic [2:0] REG_CY      = 3'd2;
    localparam logic [2:0] REG_NUM     = 3'd3;
    localparam logic [2:0] REG_MIN     = 3'd4;
    localparam logic [2:0] REG_MAX     = 3'd5;
    localparam logic [2:0] REG_FLOOR   = 3'd6;

    localparam int DIV_BITS = 46;  // dividend width: 16+20+8+2 spare
    localparam logic [25:0] DISP_MAX = 26'h3FFFFFF;

    // Which coordinate the divider works on
    typedef enum logic [1:0] {
        SEL_Z = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2
    } t_sel;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_CHECK  = 3'd1,
        ST_DIV    = 3'd2,
        ST_WAIT   = 3'd3,
        ST_WINDOW = 3'd4,
        ST_OUT    = 3'd5
    } t_state;

    typedef struct packed {
        logic load;     // capture item and convert disparity
        logic mul;      // load divider with selected dividend
        t_sel sel;
        logic store;    // latch quotient of selected coordinate
        logic emit;     // move finished point to the output register
    } t_cmd;

    typedef struct packed {
        logic pass;     // disparity valid, nonzero and not below floor
        logic div_done;
        logic in_window;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// File: src/d2p_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle
module d2p_divider (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [d2p_pkg::DIV_BITS-1:0]      i_dividend,
    input  wire [25:0]                       i_divisor,
    output logic                             o_done,
    output logic [d2p_pkg::DIV_BITS-1:0]     o_quotient
);
    localparam int CW = $clog2(d2p_pkg::DIV_BITS + 1);

    logic [d2p_pkg::DIV_BITS-1:0] r_quo, n_quo;
    logic [26:0]                  r_rem, n_rem;
    logic [25:0]                  r_dvs;
    logic [CW-1:0]                r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic [26:0]                  w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem[25:0], r_quo[d2p_pkg::DIV_BITS-1]};
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = CW'(d2p_pkg::DIV_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = w_trial - {1'b0, r_dvs};
                n_quo = {r_quo[d2p_pkg::DIV_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[d2p_pkg::DIV_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_done     = !r_busy;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// File: src/d2p_datapath.sv
`default_nettype none
`include "disparity_to_point_reprojection_unit_macros.svh"
module d2p_datapath #(
    parameter int LINE_PIXELS = 800,
    parameter int FRAME_LINES = 600
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    input  wire [2:0]            i_cfg_index,
    input  wire [19:0]           i_cfg_data,
    input  wire d2p_pkg::t_in_item i_item,
    input  wire d2p_pkg::t_cmd   i_cmd,
    output d2p_pkg::t_sts        o_sts,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output d2p_pkg::t_out_item   o_out
);
    logic [19:0] r_focal, r_cx, r_cy;
    logic [15:0] r_num, r_min, r_max, r_floor;

    logic [11:0] r_col, r_row;
    logic [11:0] r_pcol, r_prow;
    logic [7:0]  r_red, r_green, r_blue;
    logic [25:0] r_disp;
    logic        r_ok;
    logic        r_xneg, r_yneg;
    logic [35:0] r_prod;
    logic [d2p_pkg::DIV_BITS-1:0] r_zmag, r_xmag, r_ymag;
    logic        r_out_valid;
    d2p_pkg::t_out_item r_out;

    logic        w_ok;
    logic [25:0] w_disp;
    logic [4:0]  w_e;
    logic [10:0] w_m;
    logic        w_div_done;
    logic [d2p_pkg::DIV_BITS-1:0] w_quo;
    logic [19:0] w_colq, w_rowq;
    logic [19:0] w_opnd;

    // Half to unsigned Q10.16, truncated
    always_comb begin
        w_e    = i_item.disparity_half[14:10];
        w_m    = {1'b1, i_item.disparity_half[9:0]};
        w_ok   = !i_item.disparity_half[15];
        w_disp = '0;
        if (w_e == 5'd31) begin
            if (i_item.disparity_half[9:0] != 10'd0) begin
                w_ok = 1'b0;
            end
            w_disp = d2p_pkg::DISP_MAX;
        end else if (w_e == 5'd0) begin
            w_disp = 26'(i_item.disparity_half[9:8]);
        end else if (w_e >= 5'd25) begin
            w_disp = d2p_pkg::DISP_MAX;
        end else if (w_e >= 5'd9) begin
            w_disp = 26'(w_m) << (w_e - 5'd9);
        end else begin
            w_disp = 26'(w_m >> (5'd9 - w_e));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= 20'd0;
            r_cx    <= 20'd102400;
            r_cy    <= 20'd76800;
            r_num   <= 16'd2560;
            r_min   <= 16'd0;
            r_max   <= 16'd1000;
            r_floor <= 16'd7;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                d2p_pkg::REG_FOCAL: r_focal <= i_cfg_data;
                d2p_pkg::REG_CX:    r_cx    <= i_cfg_data;
                d2p_pkg::REG_CY:    r_cy    <= i_cfg_data;
                d2p_pkg::REG_NUM:   r_num   <= i_cfg_data[15:0];
                d2p_pkg::REG_MIN:   r_min   <= i_cfg_data[15:0];
                d2p_pkg::REG_MAX:   r_max   <= i_cfg_data[15:0];
                d2p_pkg::REG_FLOOR: r_floor <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Raster counters advance on every accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.load) begin
            if (32'(r_col) + 32'd1 >= 32'(LINE_PIXELS)) begin
                r_col <= '0;
                if (32'(r_row) + 32'd1 >= 32'(FRAME_LINES)) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 12'd1;
                end
            end else begin
                r_col <= r_col + 12'd1;
            end
        end
    end

    assign w_colq = {r_pcol, 8'd0};
    assign w_rowq = {r_prow, 8'd0};

    always_comb begin
        case (i_cmd.sel)
            d2p_pkg::SEL_X: w_opnd = (w_colq >= r_cx) ? w_colq - r_cx : r_cx - w_colq;
            d2p_pkg::SEL_Y: w_opnd = (r_cy >= w_rowq) ? r_cy - w_rowq : w_rowq - r_cy;
            default:        w_opnd = r_focal;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pcol  <= r_col;
            r_prow  <= r_row;
            r_red   <= i_item.red;
            r_green <= i_item.green;
            r_blue  <= i_item.blue;
            r_disp  <= w_disp;
            r_ok    <= w_ok;
            r_xneg  <= {r_col, 8'd0} < r_cx;
            r_yneg  <= r_cy < {r_row, 8'd0};
        end
        r_prod <= 36'(r_num) * 36'(w_opnd);
        if (i_cmd.store) begin
            case (i_cmd.sel)
                d2p_pkg::SEL_X: r_xmag <= w_quo;
                d2p_pkg::SEL_Y: r_ymag <= w_quo;
                default:        r_zmag <= w_quo;
            endcase
        end
    end

    d2p_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mul),
        .i_dividend ({2'b00, r_prod, 8'd0}),
        .i_divisor  (r_disp),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    function automatic logic [31:0] sat32(input logic neg,
                                          input logic [d2p_pkg::DIV_BITS-1:0] mag);
        logic [31:0] res;
        if (!neg) begin
            res = (mag > 46'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end else begin
            res = (mag >= 46'h80000000) ? 32'h80000000 : (32'd0 - mag[31:0]);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out.point_x      <= sat32(r_xneg, r_xmag);
            r_out.point_y      <= sat32(r_yneg, r_ymag);
            r_out.point_z      <= sat32(1'b1, r_zmag);
            r_out.out_red      <= r_red;
            r_out.out_green    <= r_green;
            r_out.out_blue     <= r_blue;
            r_out.pixel_column <= r_pcol;
            r_out.pixel_row    <= r_prow;
        end
    end

    assign o_sts.pass      = r_ok && (r_disp != 26'd0) && (r_disp >= 26'(r_floor));
    assign o_sts.div_done  = w_div_done;
    assign o_sts.in_window = (r_zmag >= 46'({r_min, 8'd0}))
                             && (r_zmag <= 46'({r_max, 8'd0}));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    `D2P_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.emit, o_sts.out_free,
        "point emitted over an untaken result")
    `D2P_ASSERT_NXT(a_hold_out, i_clk, i_rst_n, r_out_valid && !i_out_ready && !i_cmd.emit,
        r_out_valid && $stable(r_out), "result changed while stalled")
    `D2P_ASSERT_IMP(a_z_neg, i_clk, i_rst_n, r_out_valid, r_out.point_z[31] ||
        r_out.point_z == 32'd0, "depth must not be positive")
endmodule
`default_nettype wire

// File: src/d2p_control.sv
`default_nettype none
`include "disparity_to_point_reprojection_unit_macros.svh"
module d2p_control (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    output d2p_pkg::t_cmd   o_cmd,
    input  wire d2p_pkg::t_sts i_sts
);
    d2p_pkg::t_state r_state, n_state;
    d2p_pkg::t_sel   r_sel, n_sel;
    logic            r_go, n_go;  // product is registered in the cycle before divide

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_go    = 1'b0;
        case (r_state)
            d2p_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = d2p_pkg::ST_CHECK;
                end
            end
            d2p_pkg::ST_CHECK: begin
                if (i_sts.pass) begin
                    n_sel   = d2p_pkg::SEL_Z;
                    n_state = d2p_pkg::ST_DIV;
                end else begin
                    n_state = d2p_pkg::ST_IDLE;
                end
            end
            d2p_pkg::ST_DIV: begin
                // product settles this cycle, start divide next
                n_go    = 1'b1;
                n_state = d2p_pkg::ST_WAIT;
            end
            d2p_pkg::ST_WAIT: begin
                if (!r_go && i_sts.div_done) begin
                    case (r_sel)
                        d2p_pkg::SEL_Z: n_state = d2p_pkg::ST_WINDOW;
                        d2p_pkg::SEL_X: begin
                            n_sel   = d2p_pkg::SEL_Y;
                            n_state = d2p_pkg::ST_DIV;
                        end
                        default: n_state = d2p_pkg::ST_OUT;
                    endcase
                end
            end
            d2p_pkg::ST_WINDOW: begin
                if (i_sts.in_window) begin
                    n_sel   = d2p_pkg::SEL_X;
                    n_state = d2p_pkg::ST_DIV;
                end else begin
                    n_state = d2p_pkg::ST_IDLE;
                end
            end
            d2p_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    n_state = d2p_pkg::ST_IDLE;
                end
            end
            default: n_state = d2p_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.sel   = r_sel;
        case (r_state)
            d2p_pkg::ST_IDLE:  begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            d2p_pkg::ST_WAIT:  begin
                o_cmd.mul   = r_go;
                o_cmd.store = !r_go && i_sts.div_done;
            end
            d2p_pkg::ST_OUT:   o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= d2p_pkg::ST_IDLE;
            r_sel   <= d2p_pkg::SEL_Z;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_go    <= n_go;
        end
    end

    `D2P_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == d2p_pkg::ST_IDLE,
        "input taken outside idle")
    `D2P_ASSERT_NXT(a_go_pulse, i_clk, i_rst_n, r_go, !r_go, "divide start held")
    `D2P_ASSERT_IMP(a_one_cmd, i_clk, i_rst_n, 1'b1,
        $countones({o_cmd.load, o_cmd.mul, o_cmd.store, o_cmd.emit}) <= 1,
        "conflicting commands")
endmodule
`default_nettype wire

// File: src/disparity_to_point_reprojection_unit.sv
// A kept point passes the disparity check, the z divide, the depth window step, the x
// and y divides and the output step; the three divides run one after another on a
// single serial divider.
// A new pixel is taken only in idle, after the last one was dropped on its disparity
// or by the depth window or its result went out; a stalled result holds the unit.
// Reset (synchronous, active low) clears counters, control and output valid, and
// sets the configuration registers to their documented values.
`default_nettype none
module disparity_to_point_reprojection_unit #(
    parameter int LINE_PIXELS = 800,
    parameter int FRAME_LINES = 600
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [2:0]             i_cfg_index,
    input  wire [19:0]            i_cfg_data,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire d2p_pkg::t_in_item i_in,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output d2p_pkg::t_out_item    o_out
);
    d2p_pkg::t_cmd w_cmd;
    d2p_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    d2p_control u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    d2p_datapath #(
        .LINE_PIXELS (LINE_PIXELS),
        .FRAME_LINES (FRAME_LINES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire

// File: tb/tb_disparity_to_point_reprojection_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_disparity_to_point_reprojection_unit;

    localparam int FRAME_W = 800;
    localparam int FRAME_H = 600;
    localparam logic [15:0] HALF_POS_INF = 16'h7C00;
    localparam logic [15:0] HALF_NEG_ZERO = 16'h8000;
    localparam logic [15:0] HALF_QNAN = 16'h7E00;
    localparam logic [15:0] HALF_ONE = 16'h3C00;
    localparam logic [15:0] HALF_MAX = 16'h7BFF;
    localparam logic [15:0] HALF_MIN_SUB = 16'h0001;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    d2p_pkg::t_in_item i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    d2p_pkg::t_out_item o_out;

    always #5 i_clk = ~i_clk;

    disparity_to_point_reprojection_unit #(
        .LINE_PIXELS(FRAME_W),
        .FRAME_LINES(FRAME_H)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    // shadow of the configuration and raster position
    logic [19:0] fx, cx, cy;
    logic [15:0] numer, zmin, zmax, dfloor;
    logic [11:0] col_cnt, row_cnt;

    d2p_pkg::t_out_item points_due[$];
    int n_errors = 0;
    int n_points = 0;
    int n_pixels = 0;
    bit quiet_out = 1'b0;

    function automatic bit disp_to_q16(input logic [15:0] h, output logic [25:0] q);
        logic [4:0] e;
        logic [10:0] m;
        e = h[14:10];
        m = {1'b0, h[9:0]};
        q = '0;
        if (h[15]) return 1'b0;
        if (e == 5'd31) begin
            if (m != 0) return 1'b0;
            q = d2p_pkg::DISP_MAX;
            return 1'b1;
        end
        if (e == 0) begin
            q = 26'(m >> 8);
            return 1'b1;
        end
        if (e >= 25) begin
            q = d2p_pkg::DISP_MAX;
            return 1'b1;
        end
        m[10] = 1'b1;
        if (e >= 9) q = 26'(m) << (e - 9);
        else q = 26'(m >> (9 - e));
        return 1'b1;
    endfunction

    function automatic logic [31:0] clamp32(input bit neg, input logic [63:0] mag);
        if (!neg) return (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        if (mag >= 64'h80000000) return 32'h80000000;
        return 32'(64'h100000000 - mag);
    endfunction

    // compute the point for one pixel and step the raster counters
    function automatic bit reproject(input d2p_pkg::t_in_item px,
                                     output d2p_pkg::t_out_item pt);
        logic [25:0] d;
        logic [63:0] zmag, xmag, ymag, xo, yo, colq, rowq;
        bit xneg, yneg, ok;
        logic [11:0] c, r;
        c = col_cnt;
        r = row_cnt;
        pt = '0;
        if (32'(col_cnt) + 1 >= FRAME_W) begin
            col_cnt = '0;
            row_cnt = (32'(row_cnt) + 1 >= FRAME_H) ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        ok = disp_to_q16(px.disparity_half, d);
        if (!ok || d == 0 || d < 26'(dfloor)) return 1'b0;
        zmag = ((64'(numer) * 64'(fx)) << 8) / 64'(d);
        if (zmag < (64'(zmin) << 8) || zmag > (64'(zmax) << 8)) return 1'b0;
        colq = 64'(c) << 8;
        rowq = 64'(r) << 8;
        xneg = colq < 64'(cx);
        xo = xneg ? 64'(cx) - colq : colq - 64'(cx);
        yneg = 64'(cy) < rowq;
        yo = yneg ? rowq - 64'(cy) : 64'(cy) - rowq;
        xmag = ((64'(numer) * xo) << 8) / 64'(d);
        ymag = ((64'(numer) * yo) << 8) / 64'(d);
        pt.point_x = clamp32(xneg, xmag);
        pt.point_y = clamp32(yneg, ymag);
        pt.point_z = clamp32(1'b1, zmag);
        pt.out_red = px.red;
        pt.out_green = px.green;
        pt.out_blue = px.blue;
        pt.pixel_column = c;
        pt.pixel_row = r;
        return 1'b1;
    endfunction

    // drop valid for a random gap; valid stays high between back to back transfers
    task automatic idle_gap();
        if (!quiet_out && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (!quiet_out && $urandom_range(99) < 11);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            d2p_pkg::REG_FOCAL: fx = val;
            d2p_pkg::REG_CX: cx = val;
            d2p_pkg::REG_CY: cy = val;
            d2p_pkg::REG_NUM: numer = val[15:0];
            d2p_pkg::REG_MIN: zmin = val[15:0];
            d2p_pkg::REG_MAX: zmax = val[15:0];
            d2p_pkg::REG_FLOOR: dfloor = val[15:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (points_due.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
    endtask

    task automatic send_pixel(input d2p_pkg::t_in_item px, input bit has_exp,
                              input d2p_pkg::t_out_item exp_pt);
        d2p_pkg::t_out_item pt;
        bit kept;
        idle_gap();
        i_in_valid <= 1'b1;
        i_in <= px;
        do @(posedge i_clk); while (!o_in_ready);
        kept = reproject(px, pt);
        n_pixels++;
        if (has_exp && pt != exp_pt) begin
            $error("directed row: predicted point %h, typed %h", pt, exp_pt);
            n_errors++;
        end
        if (kept) points_due = {points_due, pt};
    endtask

    // receiver: random stalls, compare against the oldest pending point
    always @(posedge i_clk) begin
        d2p_pkg::t_out_item e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_points++;
                if (points_due.size() == 0) begin
                    $error("unexpected point %h", o_out);
                    n_errors++;
                end else begin
                    e = points_due.pop_front();
                    if (o_out.point_x !== e.point_x) begin
                        $error("point_x exp %h got %h", e.point_x, o_out.point_x);
                        n_errors++;
                    end
                    if (o_out.point_y !== e.point_y) begin
                        $error("point_y exp %h got %h", e.point_y, o_out.point_y);
                        n_errors++;
                    end
                    if (o_out.point_z !== e.point_z) begin
                        $error("point_z exp %h got %h", e.point_z, o_out.point_z);
                        n_errors++;
                    end
                    if (o_out.out_red !== e.out_red) begin
                        $error("out_red exp %h got %h", e.out_red, o_out.out_red);
                        n_errors++;
                    end
                    if (o_out.out_green !== e.out_green) begin
                        $error("out_green exp %h got %h", e.out_green, o_out.out_green);
                        n_errors++;
                    end
                    if (o_out.out_blue !== e.out_blue) begin
                        $error("out_blue exp %h got %h", e.out_blue, o_out.out_blue);
                        n_errors++;
                    end
                    if (o_out.pixel_column !== e.pixel_column) begin
                        $error("pixel_column exp %h got %h", e.pixel_column,
                               o_out.pixel_column);
                        n_errors++;
                    end
                    if (o_out.pixel_row !== e.pixel_row) begin
                        $error("pixel_row exp %h got %h", e.pixel_row, o_out.pixel_row);
                        n_errors++;
                    end
                end
            end
            i_out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    typedef struct {
        logic [15:0] disp;
        bit has_exp;
        d2p_pkg::t_out_item pt;
    } t_row;

    function automatic d2p_pkg::t_in_item mk_px(input logic [15:0] h);
        d2p_pkg::t_in_item p;
        p.disparity_half = h;
        p.red = 8'($urandom);
        p.green = 8'($urandom);
        p.blue = 8'($urandom);
        return p;
    endfunction

    function automatic logic [15:0] rand_disp();
        int k;
        k = $urandom_range(99);
        if (k < 70) return {1'b0, 5'($urandom_range(20, 12)), 10'($urandom)};
        if (k < 80) return {1'b0, 5'($urandom_range(24, 1)), 10'($urandom)};
        return 16'($urandom);
    endfunction

    initial begin
        // with fx reset to 0, z is zero and window [0..1000] keeps it
        t_row dir[$];
        t_row rw;
        d2p_pkg::t_in_item px;
        d2p_pkg::t_out_item none;
        none = '0;
        fx = 20'd0; cx = 20'd102400; cy = 20'd76800; numer = 16'd2560;
        zmin = 16'd0; zmax = 16'd1000; dfloor = 16'd7;
        col_cnt = '0; row_cnt = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // drops typed in: sign, minus zero, NaN, zero, below floor
        rw.has_exp = 1'b1; rw.pt = none;
        rw.disp = HALF_NEG_ZERO; dir = {dir, rw};
        rw.disp = 16'hBC00; dir = {dir, rw};
        rw.disp = HALF_QNAN; dir = {dir, rw};
        rw.disp = 16'h7C01; dir = {dir, rw};
        rw.disp = 16'hFFFF; dir = {dir, rw};
        rw.disp = 16'h0000; dir = {dir, rw};
        rw.disp = 16'h00FF; dir = {dir, rw};
        rw.disp = 16'h0400; dir = {dir, rw};
        rw.has_exp = 1'b0;
        rw.disp = HALF_POS_INF; dir = {dir, rw};
        rw.disp = HALF_MAX; dir = {dir, rw};
        rw.disp = HALF_ONE; dir = {dir, rw};
        rw.disp = HALF_MIN_SUB; dir = {dir, rw};
        rw.disp = 16'h03FF; dir = {dir, rw};
        rw.disp = 16'h2000; dir = {dir, rw};
        foreach (dir[i]) begin
            px = mk_px(dir[i].disp);
            send_pixel(px, dir[i].has_exp, dir[i].pt);
        end
        drain();

        // extremes: big numerator, big focal length, saturating x/y, low floor
        write_reg(d2p_pkg::REG_FOCAL, 20'hFFFFF);
        write_reg(d2p_pkg::REG_CX, 20'hFFFFF);
        write_reg(d2p_pkg::REG_CY, 20'h0);
        write_reg(d2p_pkg::REG_NUM, 20'hFFFF);
        write_reg(d2p_pkg::REG_MIN, 20'h0);
        write_reg(d2p_pkg::REG_MAX, 20'hFFFF);
        write_reg(d2p_pkg::REG_FLOOR, 20'h0);
        write_reg(3'd7, 20'h12345);
        foreach (dir[i]) send_pixel(mk_px(dir[i].disp), 1'b0, none);
        for (int i = 0; i < 6; i++) send_pixel(mk_px(16'h0100 + 16'(i)), 1'b0, none);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(d2p_pkg::REG_FOCAL, 20'(200 * 256));
                    write_reg(d2p_pkg::REG_CX, 20'(400 * 256));
                    write_reg(d2p_pkg::REG_CY, 20'(300 * 256));
                    write_reg(d2p_pkg::REG_NUM, 20'(10 * 256));
                    write_reg(d2p_pkg::REG_MIN, 20'd0);
                    write_reg(d2p_pkg::REG_MAX, 20'd1000);
                    write_reg(d2p_pkg::REG_FLOOR, 20'd7);
                end
                1: begin
                    write_reg(d2p_pkg::REG_MIN, 20'd50);
                    write_reg(d2p_pkg::REG_MAX, 20'd400);
                    write_reg(d2p_pkg::REG_FLOOR, 20'hFFFF);
                end
                2: begin
                    write_reg(d2p_pkg::REG_FOCAL, 20'($urandom));
                    write_reg(d2p_pkg::REG_CX, 20'($urandom));
                    write_reg(d2p_pkg::REG_CY, 20'($urandom));
                    write_reg(d2p_pkg::REG_NUM, 20'($urandom_range(65535)));
                    write_reg(d2p_pkg::REG_MIN, 20'd0);
                    write_reg(d2p_pkg::REG_MAX, 20'hFFFF);
                    write_reg(d2p_pkg::REG_FLOOR, 20'($urandom_range(3)));
                end
                3: quiet_out = 1'b1;
                default: begin
                    quiet_out = 1'b0;
                    write_reg(d2p_pkg::REG_FOCAL, 20'(500 * 256));
                    write_reg(d2p_pkg::REG_NUM, 20'($urandom_range(65535)));
                end
            endcase
            for (int i = 0; i < 210; i++) begin
                send_pixel(mk_px(rand_disp()), 1'b0, none);
                // hold until every pending point is out
                if (i == 100) drain();
            end
            drain();
        end

        $display("covered %0d pixels and %0d points over directed extremes and five",
                 n_pixels, n_points);
        $display("register settings, with drops, saturation and stalls on both sides");
        if (n_errors == 0 && points_due.size() == 0) begin
            $display("disparity_to_point_reprojection_unit test passed");
        end else begin
            $display("disparity_to_point_reprojection_unit test failed");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("disparity_to_point_reprojection_unit test failed");
        $finish;
    end
endmodule
`default_nettype wire
